@@ rtl/local_mean_threshold_3x3_macros.svh @@
// Assertion macros shared by the local mean threshold RTL.
`ifndef LOCAL_MEAN_THRESHOLD_3X3_MACROS_SVH
`define LOCAL_MEAN_THRESHOLD_3X3_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define LMT_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lmt assertion failed (same cycle)");

// Next-cycle implication, clocked on i_clk, off during reset.
`define LMT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lmt assertion failed (next cycle)");

`endif

@@ rtl/lmt_pkg.sv @@
// Package: constants and types of the local mean threshold block.
`timescale 1ns / 1ps
package lmt_pkg;

    localparam int PIX_W    = 16;
    localparam int SIDE_W   = 13;
    localparam int COL_W    = 12;
    localparam int MAX_SIDE = 4096;
    localparam int LB_DEPTH = 4096;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;

    localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(4096);
    localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);

    // register index, taken from paddr above the byte lane bits
    localparam logic [ADDR_W-3:0] REG_SIDE = '0;

    typedef struct packed {
        logic [SIDE_W-1:0] side;     // effective side, 1..MAX_SIDE
        logic              restart;  // side register written this cycle
    } t_cfg;

    typedef struct packed {
        logic [PIX_W-1:0] older;
        logic [PIX_W-1:0] middle;
    } t_lb_word;

    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
        t_lb_word         wr_data;
    } t_lb_req;

    typedef struct packed {
        logic above_mean;
        logic last_of_run;
        logic frame_done;
    } t_result;

    typedef struct packed {
        logic [1:0] cnt;   // results pushed this cycle, 0..2
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

@@ rtl/lmt_if.sv @@
// Interfaces: pixel input channel and result output channel.
`timescale 1ns / 1ps
interface lmt_pix_if import lmt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             mode;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, mode, pixel, input ready);
    modport sink   (input valid, mode, pixel, output ready);
endinterface

interface lmt_res_if import lmt_pkg::*; ();
    logic valid;
    logic ready;
    logic above_mean;
    logic last_of_run;
    logic frame_done;

    modport source (output valid, above_mean, last_of_run, frame_done, input ready);
    modport sink   (input valid, above_mean, last_of_run, frame_done, output ready);
endinterface

@@ rtl/lmt_cfg.sv @@
// APB register file: side length register and its clamped effective value.
`timescale 1ns / 1ps
module lmt_cfg import lmt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [SIDE_W-1:0] r_side;
    logic              sel_side;
    logic              wr_side;

    assign pready   = 1'b1;
    assign sel_side = (paddr[ADDR_W-1:2] == REG_SIDE);
    assign wr_side  = psel && penable && pwrite && pready && sel_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= SIDE_RESET;
        end else if (wr_side) begin
            r_side <= pwdata[SIDE_W-1:0];
        end
    end

    assign prdata = sel_side ? DATA_W'(r_side) : '0;

    // zero reads as one, anything past the line buffer depth as the depth
    always_comb begin
        if (r_side == '0) begin
            o_cfg.side = SIDE_W'(1);
        end else if (r_side > SIDE_MAX) begin
            o_cfg.side = SIDE_MAX;
        end else begin
            o_cfg.side = r_side;
        end
        o_cfg.restart = wr_side;
    end

endmodule

@@ rtl/lmt_line_buf.sv @@
// Line buffer memory: older and middle rows in one word, with write forwarding.
`timescale 1ns / 1ps
module lmt_line_buf import lmt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_lb_req  i_req,
    output t_lb_word o_rdata
);

    t_lb_word         mem [LB_DEPTH];
    t_lb_word         r_rd_q;
    logic [COL_W-1:0] r_rd_addr;
    logic             r_fwd_valid;
    logic [COL_W-1:0] r_fwd_addr;
    t_lb_word         r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_q    <= mem[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
        end
        if (i_req.wr_en) begin
            r_fwd_addr <= i_req.wr_addr;
            r_fwd_data <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else if (i_req.wr_en) begin
            r_fwd_valid <= 1'b1;
        end
    end

    // a read issued on the edge of a write to the same entry sees the new data
    assign o_rdata = (r_fwd_valid && (r_fwd_addr == r_rd_addr)) ? r_fwd_data : r_rd_q;

endmodule

@@ rtl/lmt_out_fifo.sv @@
// Result queue: takes up to two results a cycle, delivers one per transaction.
`timescale 1ns / 1ps
module lmt_out_fifo import lmt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    output logic      o_space2,
    lmt_res_if.source o_res
);

    t_result           r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_count;
    logic              pop;

    assign pop = (r_count != '0) && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_q[r_wp] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_q[r_wp + QPTR_W'(1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= r_wp + QPTR_W'(i_push.cnt);
            r_rp    <= r_rp + QPTR_W'(pop);
            r_count <= r_count + QCNT_W'(i_push.cnt) - QCNT_W'(pop);
        end
    end

    assign o_space2          = (r_count <= QCNT_W'(QDEPTH - 2));
    assign o_res.valid       = (r_count != '0);
    assign o_res.above_mean  = r_q[r_rp].above_mean;
    assign o_res.last_of_run = r_q[r_rp].last_of_run;
    assign o_res.frame_done  = r_q[r_rp].frame_done;

endmodule

@@ rtl/local_mean_threshold_3x3.sv @@
// Top level: 3x3 local mean threshold over a square pixel stream.
`timescale 1ns / 1ps
`include "local_mean_threshold_3x3_macros.svh"
// Usage:
//  - i_pix carries one pixel per transaction, row-major; mode=1 marks a drain
//    item. After the last image row send one drain row of side_length items.
//  - o_res carries one bit per image pixel: above_mean, plus last_of_run on the
//    last result of an input item and frame_done on the final result of a frame.
//  - APB register 0 (byte address 0) holds side_length; writing it restarts the
//    frame at row 0, column 0. Write it only while the block is idle.
//  - Results lag one row and one column: the first image row gives no results,
//    the last pixel of a row also gives the result for the last column above.
//  - Pipeline: accept (line buffer read) -> window update (read-modify-write of
//    the line buffer entry) -> threshold compare and push into a 4-entry queue.
//    With the queue empty stage 2 does not wait, and a result is valid once pushed.
//  - Throughput: one input item per cycle unless stalled; the line buffer takes
//    one read and one write each cycle. Output drains one result per ready cycle.
//  - Stall: when o_res is held, stage 2 waits while fewer than two queue entries
//    are free and i_pix.ready drops once both stages are full; nothing is lost.
//  - Reset: counters at row 0, column 0, window cleared, side_length 4096.
//    Line buffer contents are not cleared; entries not yet written only feed
//    neighbours that lie outside the image.
module local_mean_threshold_3x3 import lmt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    lmt_pix_if.sink           i_pix,
    lmt_res_if.source         o_res
);

    // first-stage item: position flags resolved at accept time
    typedef struct packed {
        logic [COL_W-1:0] c;
        logic [PIX_W-1:0] v;
        logic             in_img;   // image row, not the drain row
        logic             has_row;  // row >= 1, a row above exists to judge
        logic             top;      // row >= 2
        logic             left1;    // col >= 2
        logic             left2;    // col >= 1
        logic             c_last;
        logic             fdone;
    } t_s1;

    typedef struct packed {
        logic emit1;   // judge window column 1
        logic emit2;   // judge window column 2 (row end)
        logic top;
        logic bot;
        logic left1;
        logic left2;
        logic fdone;
    } t_s2;

    t_cfg             cfg;
    t_lb_req          lb_req;
    t_lb_word         lb_rdata;
    t_push            push;
    logic             q_space2;

    logic [SIDE_W-1:0] r_row;
    logic [COL_W-1:0]  r_col;
    logic [SIDE_W-1:0] n_row;
    logic [COL_W-1:0]  n_col;
    logic [COL_W-1:0]  side_m1;

    logic             r_s1_valid;
    t_s1              r_s1;
    t_s1              n_s1;
    logic             r_s2_valid;
    t_s2              r_s2;

    logic [PIX_W-1:0] r_win [3][3];   // [row][col], col 2 newest

    logic             accept;
    logic             in_ready;
    logic             s1_adv;
    logic             s2_adv;
    logic             s2_free;

    logic [17:0]      cs [3];
    logic [19:0]      sum1;
    logic [19:0]      sum2;
    logic [1:0]       rc;
    logic [3:0]       cnt1;
    logic [3:0]       cnt2;
    logic [19:0]      prod1;
    logic [19:0]      prod2;
    t_result          res1;
    t_result          res2;

    lmt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lmt_line_buf u_line_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (lb_req),
        .o_rdata (lb_rdata)
    );

    lmt_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_space2 (q_space2),
        .o_res    (o_res)
    );

    // ---- handshake / stage advance ----
    assign s2_adv      = r_s2_valid && q_space2;
    assign s2_free     = !r_s2_valid || s2_adv;
    assign s1_adv      = r_s1_valid && s2_free;
    assign in_ready    = !r_s1_valid || s1_adv;
    assign i_pix.ready = in_ready;
    assign accept      = i_pix.valid && in_ready;

    // ---- position counters ----
    assign side_m1 = COL_W'(cfg.side - SIDE_W'(1));

    always_comb begin
        n_s1.c       = r_col;
        n_s1.in_img  = (r_row < cfg.side);
        n_s1.v       = (i_pix.mode || !n_s1.in_img) ? '0 : i_pix.pixel;
        n_s1.has_row = (r_row != '0);
        n_s1.top     = (r_row >= SIDE_W'(2));
        n_s1.left1   = (r_col >= COL_W'(2));
        n_s1.left2   = (r_col != '0);
        n_s1.c_last  = (r_col == side_m1);
        n_s1.fdone   = (r_row == cfg.side) && n_s1.c_last;

        n_col = r_col + COL_W'(1);
        n_row = r_row;
        if (n_s1.c_last) begin
            n_col = '0;
            n_row = (r_row == cfg.side) ? '0 : r_row + SIDE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (cfg.restart) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // ---- line buffer: read at accept, write back when the item moves on ----
    always_comb begin
        lb_req.rd_en          = accept;
        lb_req.rd_addr        = r_col;
        lb_req.wr_en          = s1_adv && r_s1.in_img;
        lb_req.wr_addr        = r_s1.c;
        lb_req.wr_data.older  = lb_rdata.middle;
        lb_req.wr_data.middle = r_s1.v;
    end

    // ---- stage 1 / stage 2 control and window ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= n_s1;
        end
        if (s1_adv) begin
            r_s2.emit1 <= r_s1.has_row && r_s1.left2;
            r_s2.emit2 <= r_s1.has_row && r_s1.c_last;
            r_s2.top   <= r_s1.top;
            r_s2.bot   <= r_s1.in_img;
            r_s2.left1 <= r_s1.left1;
            r_s2.left2 <= r_s1.left2;
            r_s2.fdone <= r_s1.fdone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[i][k] <= '0;
                end
            end
        end else if (s1_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= r_win[i][1];
                r_win[i][1] <= r_win[i][2];
            end
            r_win[0][2] <= lb_rdata.older;
            r_win[1][2] <= lb_rdata.middle;
            r_win[2][2] <= r_s1.v;
        end
    end

    // ---- stage 2: masked column sums, count, compare ----
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cs[k] = (r_s2.top ? 18'(r_win[0][k]) : 18'd0) + 18'(r_win[1][k])
                  + (r_s2.bot ? 18'(r_win[2][k]) : 18'd0);
        end
        sum1  = (r_s2.left1 ? 20'(cs[0]) : 20'd0) + 20'(cs[1]) + 20'(cs[2]);
        sum2  = (r_s2.left2 ? 20'(cs[1]) : 20'd0) + 20'(cs[2]);
        rc    = 2'd1 + 2'(r_s2.top) + 2'(r_s2.bot);
        cnt1  = 4'(rc) * (4'd2 + 4'(r_s2.left1));
        cnt2  = 4'(rc) * (4'd1 + 4'(r_s2.left2));
        prod1 = 20'(r_win[1][1]) * 20'(cnt1);
        prod2 = 20'(r_win[1][2]) * 20'(cnt2);

        res1.above_mean  = (prod1 > sum1);
        res1.last_of_run = !r_s2.emit2;
        res1.frame_done  = !r_s2.emit2 && r_s2.fdone;
        res2.above_mean  = (prod2 > sum2);
        res2.last_of_run = 1'b1;
        res2.frame_done  = r_s2.fdone;

        push.cnt  = s2_adv ? (2'(r_s2.emit1) + 2'(r_s2.emit2)) : 2'd0;
        push.res0 = r_s2.emit1 ? res1 : res2;
        push.res1 = res2;
    end

    // ---- checks ----
    `LMT_ASSERT_IMPL(a_col_in_range, 1'b1, r_col <= side_m1)
    `LMT_ASSERT_IMPL(a_row_in_range, 1'b1, r_row <= cfg.side)
    `LMT_ASSERT_NEXT(a_s2_loaded, s1_adv, r_s2_valid)
    `LMT_ASSERT_IMPL(a_done_is_last, o_res.valid && o_res.frame_done, o_res.last_of_run)

endmodule
